// File: hdl/sjrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjrr_pkg: shared constants for the job sort and round-robin dealer
// Field widths and parameter defaults used by the top level and the dealer.
// ----------------------------------------------------------------------------
package sjrr_pkg;

  // Batch size default
  localparam int unsigned JOBS_DEFAULT = 8;

  // Field widths
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned WORKER_W = 8;
  localparam int unsigned SLOT_W   = 3;

  // Worker count after reset
  localparam logic [WORKER_W-1:0] WORKER_COUNT_RESET = WORKER_W'(1);

endpackage

// File: hdl/sort_jobs_round_robin_deal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_jobs_round_robin_deal: batch exchange sort and round-robin dealer
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------------
//   in        | in_valid_i / in_ready_o   | job_length_i
//   out       | out_valid_o / out_ready_i | worker_index_o, slot_index_o,
//             |                           | assigned_length_o, last_result_o
//   config    | worker_count_we_i         | worker_count_i
//
// Loads are accepted back to back. On the last load of a batch the block
// sorts with one comparator and a one-write, one-read job store: each pass
// reads its outer entry, compares it with every later entry and writes the
// smallest back. Dealing then reads each result from the store and loads it
// into the output register. in_ready_o is low from the last load until the
// final result is in the output register; a stalled output holds the
// dealer. Reset clears control state only; the job store is not cleared.
// ----------------------------------------------------------------------------
module sort_jobs_round_robin_deal import sjrr_pkg::*; #(
  parameter int unsigned JOBS = JOBS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                worker_count_we_i,
  input  logic [WORKER_W-1:0] worker_count_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [LEN_W-1:0]    job_length_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WORKER_W-1:0] worker_index_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic [LEN_W-1:0]    assigned_length_o,
  output logic                last_result_o
);

  localparam int unsigned AW = $clog2(JOBS);

  typedef enum logic [2:0] {
    S_LOAD,
    S_RDA,
    S_LDA,
    S_CMP,
    S_WB,
    S_RD,
    S_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       load_cnt_q, load_cnt_d;
  logic [AW-1:0]       a_q, a_d;
  logic [AW-1:0]       b_q, b_d;
  logic [LEN_W-1:0]    cur_q, cur_d;
  logic [WORKER_W-1:0] nw_q;
  logic [WORKER_W-1:0] nw_eff;

  logic                out_valid_q, out_valid_d;
  logic [WORKER_W-1:0] worker_q, worker_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic                last_q, last_d;

  logic [LEN_W-1:0]    mem [JOBS];
  logic                we;
  logic [AW-1:0]       waddr;
  logic [LEN_W-1:0]    wdata;
  logic [AW-1:0]       raddr;
  logic [LEN_W-1:0]    rd_data_q;

  logic                in_xfer;
  logic                ld_out;
  logic                deal_start;
  logic                deal_step;
  logic [AW-1:0]       deal_addr;
  logic [WORKER_W-1:0] deal_worker;
  logic [SLOT_W-1:0]   deal_slot;
  logic                deal_last;

  // A worker count of zero deals as one worker
  assign nw_eff = (nw_q == '0) ? WORKER_W'(1) : nw_q;

  sjrr_dealer #(
    .JOBS (JOBS)
  ) u_dealer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (deal_start),
    .step_i   (deal_step),
    .nw_i     (nw_eff),
    .addr_o   (deal_addr),
    .worker_o (deal_worker),
    .slot_o   (deal_slot),
    .last_o   (deal_last)
  );

  assign in_ready_o = (state_q == S_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign ld_out     = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign deal_step  = ld_out;

  // Sequencer: load, exchange sort through one comparator, deal
  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    a_d         = a_q;
    b_d         = b_q;
    cur_d       = cur_q;
    we          = 1'b0;
    waddr       = load_cnt_q;
    wdata       = job_length_i;
    raddr       = a_q;
    deal_start  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    worker_d    = worker_q;
    slot_d      = slot_q;
    len_d       = len_q;
    last_d      = last_q;

    case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          we = 1'b1;
          if (load_cnt_q == AW'(JOBS - 1)) begin
            load_cnt_d = '0;
            a_d        = '0;
            state_d    = S_RDA;
          end else begin
            load_cnt_d = load_cnt_q + AW'(1);
          end
        end
      end
      S_RDA: begin
        raddr   = a_q;
        state_d = S_LDA;
      end
      S_LDA: begin
        cur_d   = rd_data_q;
        b_d     = a_q + AW'(1);
        raddr   = a_q + AW'(1);
        state_d = S_CMP;
      end
      S_CMP: begin
        // Swap: the larger value moves out to b, the smaller one is held
        if (cur_q > rd_data_q) begin
          we    = 1'b1;
          waddr = b_q;
          wdata = cur_q;
          cur_d = rd_data_q;
        end
        raddr = b_q + AW'(1);
        if (b_q == AW'(JOBS - 1)) begin
          state_d = S_WB;
        end else begin
          b_d = b_q + AW'(1);
        end
      end
      S_WB: begin
        we    = 1'b1;
        waddr = a_q;
        wdata = cur_q;
        if (a_q == AW'(JOBS - 2)) begin
          deal_start = 1'b1;
          state_d    = S_RD;
        end else begin
          a_d     = a_q + AW'(1);
          state_d = S_RDA;
        end
      end
      S_RD: begin
        raddr   = deal_addr;
        state_d = S_OUT;
      end
      S_OUT: begin
        raddr = deal_addr;
        if (ld_out) begin
          out_valid_d = 1'b1;
          worker_d    = deal_worker;
          slot_d      = deal_slot;
          len_d       = rd_data_q;
          last_d      = deal_last;
          state_d     = deal_last ? S_LOAD : S_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Hold state, counters, worker count and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      load_cnt_q  <= '0;
      a_q         <= '0;
      b_q         <= '0;
      nw_q        <= WORKER_COUNT_RESET;
      out_valid_q <= 1'b0;
      worker_q    <= '0;
      slot_q      <= '0;
      len_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      a_q         <= a_d;
      b_q         <= b_d;
      out_valid_q <= out_valid_d;
      worker_q    <= worker_d;
      slot_q      <= slot_d;
      len_q       <= len_d;
      last_q      <= last_d;
      if (worker_count_we_i) begin
        nw_q <= worker_count_i;
      end
    end
  end

  // Held comparator operand
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // Job store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[raddr];
  end

  assign out_valid_o       = out_valid_q;
  assign worker_index_o    = worker_q;
  assign slot_index_o      = slot_q;
  assign assigned_length_o = len_q;
  assign last_result_o     = last_q;

  // The final load of a batch starts the sort
  a_last_load_sorts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (load_cnt_q == AW'(JOBS - 1))) |=> (state_q == S_RDA))
    else $error("sort did not start after the final load");

  // The inner index always runs ahead of the outer one
  a_cmp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (b_q > a_q))
    else $error("compare index not above outer index");

  // Loading the flagged result returns the block to loading
  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_out && deal_last) |=> (state_q == S_LOAD) && out_valid_o && last_result_o)
    else $error("final result did not end the batch");

  // The load count is clear outside loading
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> (load_cnt_q == '0))
    else $error("load count nonzero during sort or deal");

endmodule

// File: hdl/sjrr_dealer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjrr_dealer: round-robin position walker
// Walks sorted positions worker by worker: w, w+W, w+2W, ... then the next
// worker, and flags the final position of the batch.
// ----------------------------------------------------------------------------
module sjrr_dealer import sjrr_pkg::*; #(
  parameter int unsigned JOBS = JOBS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       step_i,
  input  logic [WORKER_W-1:0]        nw_i,
  output logic [$clog2(JOBS)-1:0]    addr_o,
  output logic [WORKER_W-1:0]        worker_o,
  output logic [SLOT_W-1:0]          slot_o,
  output logic                       last_o
);

  localparam int unsigned AW = $clog2(JOBS);
  localparam int unsigned PW = $clog2(JOBS + 256);
  localparam int unsigned WW = $clog2(JOBS + 1);

  logic [PW-1:0]     pos_q, pos_d;
  logic [WW-1:0]     w_q, w_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [PW-1:0]     pos_sum;
  logic [PW-1:0]     w_inc;
  logic              wrap;

  // Next position of this worker, or first position of the next worker
  assign pos_sum = pos_q + PW'(nw_i);
  assign w_inc   = PW'(w_q) + PW'(1);
  assign wrap    = pos_sum >= PW'(JOBS);
  assign last_o  = wrap && ((w_inc >= PW'(nw_i)) || (w_inc >= PW'(JOBS)));

  always_comb begin
    pos_d  = pos_q;
    w_d    = w_q;
    slot_d = slot_q;
    if (start_i) begin
      pos_d  = '0;
      w_d    = '0;
      slot_d = '0;
    end else if (step_i) begin
      if (wrap) begin
        pos_d  = w_inc;
        w_d    = w_q + WW'(1);
        slot_d = '0;
      end else begin
        pos_d  = pos_sum;
        slot_d = slot_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      w_q    <= '0;
      slot_q <= '0;
    end else begin
      pos_q  <= pos_d;
      w_q    <= w_d;
      slot_q <= slot_d;
    end
  end

  assign addr_o   = pos_q[AW-1:0];
  assign worker_o = WORKER_W'(w_q);
  assign slot_o   = slot_q;

endmodule

// File: verif/tb_sort_jobs_round_robin_deal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sort_jobs_round_robin_deal: self-checking bench for the job sort dealer
// Loads batches of job lengths, predicts the sorted round-robin deal and
// compares every output transfer field by field, under several worker counts
// and idle patterns, including a long output hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_sort_jobs_round_robin_deal;
  import sjrr_pkg::*;

  localparam int unsigned JOBS           = JOBS_DEFAULT;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned DIRECTED_ROWS  = 24;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_DST,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [WORKER_W-1:0] worker;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    length;
    logic                last;
  } deal_t;

  typedef struct packed {
    logic                cfg_we;
    logic [WORKER_W-1:0] cfg;
    logic [LEN_W-1:0]    length;
  } job_row_t;

  typedef struct {
    idle_mode_e          mode;
    logic [WORKER_W-1:0] workers;
    int unsigned         batches;
    bit                  hold_off;
  } phase_t;

  logic                clk_i;
  logic                rst_ni;
  logic                worker_count_we_i;
  logic [WORKER_W-1:0] worker_count_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [LEN_W-1:0]    job_length_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [WORKER_W-1:0] worker_index_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [LEN_W-1:0]    assigned_length_o;
  logic                last_result_o;

  // Directed loads: mixed extremes under the reset worker count, then a
  // reversed batch with more workers than jobs, then duplicates with zero
  // workers (treated as one).
  job_row_t directed_jobs [DIRECTED_ROWS] = '{
    '{1'b0, 8'd0,   8'd255}, '{1'b0, 8'd0, 8'd0},   '{1'b0, 8'd0, 8'd128},
    '{1'b0, 8'd0,   8'd1},   '{1'b0, 8'd0, 8'd254}, '{1'b0, 8'd0, 8'd127},
    '{1'b0, 8'd0,   8'd0},   '{1'b0, 8'd0, 8'd255},
    '{1'b1, 8'd255, 8'd80},  '{1'b0, 8'd0, 8'd70},  '{1'b0, 8'd0, 8'd60},
    '{1'b0, 8'd0,   8'd50},  '{1'b0, 8'd0, 8'd40},  '{1'b0, 8'd0, 8'd30},
    '{1'b0, 8'd0,   8'd20},  '{1'b0, 8'd0, 8'd10},
    '{1'b1, 8'd0,   8'd9},   '{1'b0, 8'd0, 8'd3},   '{1'b0, 8'd0, 8'd9},
    '{1'b0, 8'd0,   8'd3},   '{1'b0, 8'd0, 8'd9},   '{1'b0, 8'd0, 8'd3},
    '{1'b0, 8'd0,   8'd9},   '{1'b0, 8'd0, 8'd3}
  };

  // First batch after reset: one worker takes the whole sorted batch.
  deal_t reset_batch_deals [JOBS] = '{
    '{8'd0, 3'd0, 8'd0,   1'b0}, '{8'd0, 3'd1, 8'd0,   1'b0},
    '{8'd0, 3'd2, 8'd1,   1'b0}, '{8'd0, 3'd3, 8'd127, 1'b0},
    '{8'd0, 3'd4, 8'd128, 1'b0}, '{8'd0, 3'd5, 8'd254, 1'b0},
    '{8'd0, 3'd6, 8'd255, 1'b0}, '{8'd0, 3'd7, 8'd255, 1'b1}
  };

  phase_t phases [PHASES] = '{
    '{IDLE_NONE, 8'd3,   3, 1'b0},
    '{IDLE_SRC,  8'd8,   3, 1'b0},
    '{IDLE_DST,  8'd255, 3, 1'b0},
    '{IDLE_BOTH, 8'd5,   3, 1'b0},
    '{IDLE_NONE, 8'd0,   3, 1'b1},
    '{IDLE_SRC,  8'd9,   3, 1'b0},
    '{IDLE_DST,  8'd1,   3, 1'b0},
    '{IDLE_BOTH, 8'd6,   3, 1'b0}
  };

  // Predictor state
  logic [LEN_W-1:0]    batch_jobs [JOBS];
  int unsigned         batch_fill;
  logic [WORKER_W-1:0] model_workers;
  deal_t               pending_deals [$];

  // Run bookkeeping
  idle_mode_e  idle_mode;
  int unsigned hold_requests;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned loads_seen;
  int unsigned batches_loaded;
  int unsigned deals_checked;

  sort_jobs_round_robin_deal #(
    .JOBS (JOBS)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .worker_count_we_i (worker_count_we_i),
    .worker_count_i    (worker_count_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .job_length_i      (job_length_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .worker_index_o    (worker_index_o),
    .slot_index_o      (slot_index_o),
    .assigned_length_o (assigned_length_o),
    .last_result_o     (last_result_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Sort a copy of the batch and deal it worker-major, slot-minor
  task automatic deal_sorted_batch();
    logic [LEN_W-1:0] sorted [JOBS];
    logic [LEN_W-1:0] swap;
    int unsigned      lanes;
    int unsigned      slot;
    deal_t            d;
    sorted = batch_jobs;
    for (int a = 0; a < JOBS; a++) begin
      for (int b = a + 1; b < JOBS; b++) begin
        if (sorted[a] > sorted[b]) begin
          swap      = sorted[a];
          sorted[a] = sorted[b];
          sorted[b] = swap;
        end
      end
    end
    lanes = (model_workers == '0) ? 1 : model_workers;
    for (int unsigned w = 0; w < lanes && w < JOBS; w++) begin
      slot = 0;
      for (int unsigned p = w; p < JOBS; p += lanes) begin
        d.worker = WORKER_W'(w);
        d.slot   = SLOT_W'(slot);
        d.length = sorted[p];
        d.last   = (w == lanes - 1 || w == JOBS - 1) && (p + lanes >= JOBS);
        pending_deals.push_back(d);
        slot++;
      end
    end
  endtask

  // Track config, loads and output transfers at every rising edge
  always @(posedge clk_i) begin
    deal_t got;
    deal_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (worker_count_we_i) begin
        model_workers = worker_count_i;
      end
      if (in_valid_i && in_ready_o) begin
        batch_jobs[batch_fill] = job_length_i;
        batch_fill++;
        loads_seen++;
        if (batch_fill == JOBS) begin
          batch_fill = 0;
          if (batches_loaded == 0) begin
            foreach (reset_batch_deals[i]) pending_deals.push_back(reset_batch_deals[i]);
          end else begin
            deal_sorted_batch();
          end
          batches_loaded++;
        end
      end
      if (out_valid_o && out_ready_i) begin
        got = '{worker_index_o, slot_index_o, assigned_length_o, last_result_o};
        if (pending_deals.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected deal: w%0d s%0d len %0d last %0b",
                     got.worker, got.slot, got.length, got.last);
          end
        end else begin
          want = pending_deals.pop_front();
          deals_checked++;
          if (got.worker !== want.worker || got.slot !== want.slot ||
              got.length !== want.length || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("deal %0d: expected w%0d s%0d len %0d last %0b, got w%0d s%0d len %0d last %0b",
                       deals_checked, want.worker, want.slot, want.length, want.last,
                       got.worker, got.slot, got.length, got.last);
            end
          end
        end
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("timeout after %0d quiet cycles", quiet_cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Drive output ready; serve a hold-off request with a counted stall
  initial begin
    int unsigned hold_served;
    hold_served = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        for (int unsigned i = 0; i < HOLD_CYCLES; i++) begin
          out_ready_i <= 1'b0;
          @(negedge clk_i);
        end
      end
      case (idle_mode)
        IDLE_DST:  out_ready_i <= ($urandom_range(0, 99) >= 75);
        IDLE_BOTH: out_ready_i <= ($urandom_range(0, 99) >= 12);
        default:   out_ready_i <= 1'b1;
      endcase
    end
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SRC:  return $urandom_range(0, 99) < 75;
      IDLE_BOTH: return $urandom_range(0, 99) < 12;
      default:   return 1'b0;
    endcase
  endfunction

  // Offer one job and hold it until the transfer; returns on a falling edge
  // with valid still high so back-to-back loads need no gap
  task automatic send_job(input logic [LEN_W-1:0] length);
    while (sender_idles()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    job_length_i <= length;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the worker count once every pending deal is out
  task automatic set_workers(input logic [WORKER_W-1:0] count);
    in_valid_i <= 1'b0;
    while (pending_deals.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    worker_count_we_i <= 1'b1;
    worker_count_i    <= count;
    @(negedge clk_i);
    worker_count_we_i <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] random_length(input int unsigned flavor);
    case (flavor)
      0:       return LEN_W'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2:       return LEN_W'($urandom_range(250, 255));
      default: return LEN_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int unsigned flavor;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    job_length_i      = '0;
    worker_count_we_i = 1'b0;
    worker_count_i    = '0;
    idle_mode         = IDLE_NONE;
    hold_requests     = 0;
    quiet_cycles      = 0;
    mismatches        = 0;
    loads_seen        = 0;
    batches_loaded    = 0;
    deals_checked     = 0;
    batch_fill        = 0;
    model_workers     = WORKER_COUNT_RESET;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed batches
    foreach (directed_jobs[i]) begin
      if (directed_jobs[i].cfg_we) set_workers(directed_jobs[i].cfg);
      send_job(directed_jobs[i].length);
    end

    // Random batches, one worker count and idle pattern per phase
    foreach (phases[k]) begin
      set_workers(phases[k].workers);
      idle_mode = phases[k].mode;
      if (phases[k].hold_off) hold_requests++;
      for (int unsigned b = 0; b < phases[k].batches; b++) begin
        flavor = $urandom_range(0, 5);
        for (int unsigned j = 0; j < JOBS; j++) send_job(random_length(flavor));
      end
    end

    // Drain and let late transfers show up
    in_valid_i <= 1'b0;
    while (pending_deals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d loads in %0d batches, %0d deals checked, %0d mismatches",
             loads_seen, batches_loaded, deals_checked, mismatches);
    $display("worker counts 0, 1, 3, 5, 6, 8, 9, 255; four idle patterns; one long output hold-off");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
